FILE: rtl/core/ptm_pkg.sv
package ptm_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_W     = 33;
  localparam int TURN_BITS    = 32;
  localparam int TRIG_W       = 18;
  localparam int TRIG_MAG_W   = 17;
  localparam int Q30_TO_Q16   = 14;
  localparam int ROUND_Q16    = 8192;
  localparam int Q_ONE        = 65536;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic [TRIG_MAG_W-1:0]      trig_mag_t;
  typedef logic [1:0]                 quad_t;

  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  // CORDIC gain in Q2.30
  localparam cordic_t CORDIC_GAIN = 33'sd652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Q2.30 to Q1.16, round half up, clamp to [-1.0, +1.0]
  function automatic trig_t cordic_to_q16(cordic_t v);
    cordic_t r;
    r = (v + cordic_t'(ROUND_Q16)) >>> Q30_TO_Q16;
    if (r > cordic_t'(Q_ONE)) begin
      r = cordic_t'(Q_ONE);
    end else if (r < -cordic_t'(Q_ONE)) begin
      r = -cordic_t'(Q_ONE);
    end
    return trig_t'(r);
  endfunction

  function automatic trig_mag_t trig_mag(trig_t v);
    trig_t n;
    n = -v;
    return v[TRIG_W-1] ? trig_mag_t'(n) : trig_mag_t'(v);
  endfunction

endpackage

FILE: rtl/core/ptm_in_if.sv
interface ptm_in_if #(
  parameter int DATA_WIDTH = 32,
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] scale;
  logic signed [DATA_WIDTH-1:0] camera_x;
  logic signed [DATA_WIDTH-1:0] camera_y;
  logic signed [DATA_WIDTH-1:0] camera_z;
  logic signed [DATA_WIDTH-1:0] particle_x;
  logic signed [DATA_WIDTH-1:0] particle_y;
  logic signed [DATA_WIDTH-1:0] particle_z;
  logic [ANGLE_BITS-1:0]        angle;

  modport source (
    output valid, scale, camera_x, camera_y, camera_z,
    output particle_x, particle_y, particle_z, angle,
    input  ready
  );

  modport sink (
    input  valid, scale, camera_x, camera_y, camera_z,
    input  particle_x, particle_y, particle_z, angle,
    output ready
  );
endinterface

FILE: rtl/core/ptm_out_if.sv
interface ptm_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_cos_a;
  logic signed [DATA_WIDTH-1:0] rot_neg_sin;
  logic signed [DATA_WIDTH-1:0] rot_sin;
  logic signed [DATA_WIDTH-1:0] rot_cos_b;
  logic signed [DATA_WIDTH-1:0] depth_scale;
  logic signed [DATA_WIDTH-1:0] move_x;
  logic signed [DATA_WIDTH-1:0] move_y;
  logic signed [DATA_WIDTH-1:0] move_z;

  modport source (
    output valid, rot_cos_a, rot_neg_sin, rot_sin, rot_cos_b,
    output depth_scale, move_x, move_y, move_z,
    input  ready
  );

  modport sink (
    input  valid, rot_cos_a, rot_neg_sin, rot_sin, rot_cos_b,
    input  depth_scale, move_x, move_y, move_z,
    output ready
  );
endinterface

FILE: rtl/core/ptm_mul.sv
module ptm_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic [AW-1:0]        a_mag,
  input  logic [BW-1:0]        b_mag,
  input  logic                 neg,
  output logic signed [DW-1:0] res_r
);

  localparam int ALO  = (AW + 1) / 2;
  localparam int AHI  = AW - ALO;
  localparam int BLO  = (BW + 1) / 2;
  localparam int BHI  = BW - BLO;
  localparam int PW   = AW + BW;
  localparam int FRAC = ptm_pkg::FRAC_BITS;
  localparam int MW   = PW + 1 - FRAC;

  localparam logic [MW-1:0] M_MAX   = {{(MW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [MW-1:0] M_MIN   = M_MAX + MW'(1);
  localparam logic [PW:0]   M_ROUND = (PW+1)'(1) << (FRAC - 1);

  logic [ALO+BLO-1:0] pp_ll_r;
  logic [ALO+BHI-1:0] pp_lh_r;
  logic [AHI+BLO-1:0] pp_hl_r;
  logic [AHI+BHI-1:0] pp_hh_r;
  logic               neg_a_r;
  logic               neg_b_r;
  logic [PW-1:0]      prod_r;

  logic [PW:0]        rnd_nxt;
  logic [MW-1:0]      mag_nxt;
  logic [MW-1:0]      clip_nxt;
  logic [DW-1:0]      res_nxt;

  // four half-width partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll_r <= a_mag[ALO-1:0]  * b_mag[BLO-1:0];
      pp_lh_r <= a_mag[ALO-1:0]  * b_mag[BW-1:BLO];
      pp_hl_r <= a_mag[AW-1:ALO] * b_mag[BLO-1:0];
      pp_hh_r <= a_mag[AW-1:ALO] * b_mag[BW-1:BLO];
      neg_a_r <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r  <= PW'(pp_ll_r)
               + (PW'(pp_lh_r) << BLO)
               + (PW'(pp_hl_r) << ALO)
               + (PW'(pp_hh_r) << (ALO + BLO));
      neg_b_r <= neg_a_r;
    end
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    rnd_nxt  = {1'b0, prod_r} + M_ROUND;
    mag_nxt  = rnd_nxt[PW:FRAC];
    clip_nxt = neg_b_r ? ((mag_nxt > M_MIN) ? M_MIN : mag_nxt)
                       : ((mag_nxt > M_MAX) ? M_MAX : mag_nxt);
    res_nxt  = neg_b_r ? -clip_nxt[DW-1:0] : clip_nxt[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res_r <= $signed(res_nxt);
    end
  end

endmodule

FILE: rtl/core/particle_transform_matrix.sv
// An accepted input beat passes one input stage, 16 CORDIC stages, one sin/cos
// mapping stage and three multiply stages (partial products, sum, round and
// saturate) on its way to the output. Throughput: one beat per cycle unless the
// output stalls; every stage takes the next item as the one ahead moves on, and
// a stall backs up only as far as the first empty stage. Reset clears the stage
// valid bits only; data registers are not reset.
module particle_transform_matrix #(
  parameter int DATA_WIDTH = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ptm_in_if.sink    in_beat,
  ptm_out_if.source out_beat
);

  localparam int DW     = DATA_WIDTH;
  localparam int TW     = DW + 1;
  localparam int CW     = ptm_pkg::CORDIC_W;
  localparam int ITERS  = ptm_pkg::CORDIC_ITERS;
  localparam int TURN_W = ptm_pkg::TURN_BITS;
  localparam int S2_ST  = 3;
  localparam int MV_ST  = 6;
  localparam int ST_MAP = ITERS + 1;
  localparam int ST_PP  = ITERS + 2;
  localparam int ST_OUT = ITERS + 4;
  localparam int NST    = ITERS + 5;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  logic [TURN_W-1:0] turn_nxt;

  logic [DW-1:0]        sc_mag_r;
  logic signed [TW-1:0] tsum_r [3];
  logic [TW-1:0]        tmag_r [1:S2_ST][3];
  logic                 tneg_r [1:S2_ST][3];

  ptm_pkg::cordic_t cx_r [0:ITERS];
  ptm_pkg::cordic_t cy_r [0:ITERS];
  ptm_pkg::cordic_t cz_r [0:ITERS];
  ptm_pkg::quad_t   qd_r [0:ITERS];

  ptm_pkg::trig_mag_t c_mag_r, s_mag_r, c_mag_nxt, s_mag_nxt;
  logic               c_neg_r, s_neg_r, c_neg_nxt, s_neg_nxt;
  ptm_pkg::trig_t     cr_nxt, sr_nxt;
  ptm_pkg::trig_mag_t crm_nxt, srm_nxt;

  logic signed [DW-1:0] s2_res;
  logic signed [DW-1:0] s2_r [S2_ST+1:ST_OUT];
  logic signed [DW-1:0] mv_res [3];
  logic signed [DW-1:0] mv_r [MV_ST+1:ST_OUT][3];
  logic signed [DW-1:0] cos_res;
  logic signed [DW-1:0] sin_res;

  // ---------------------------------------------------------------- control
  assign en[NST-1] = !v_r[NST-1] || out_beat.ready;

  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_beat.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_beat.ready = en[0];

  // ---------------------------------------------------------------- input stage
  assign turn_nxt = {in_beat.angle, {(TURN_W-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sc_mag_r  <= in_beat.scale[DW-1] ? DW'(-in_beat.scale) : DW'(in_beat.scale);
      tsum_r[0] <= TW'(in_beat.camera_x) + TW'(in_beat.particle_x);
      tsum_r[1] <= TW'(in_beat.camera_y) + TW'(in_beat.particle_y);
      tsum_r[2] <= TW'(in_beat.camera_z) + TW'(in_beat.particle_z);
      cx_r[0]   <= ptm_pkg::CORDIC_GAIN;
      cy_r[0]   <= '0;
      cz_r[0]   <= ptm_pkg::cordic_t'(turn_nxt[TURN_W-3:0]);
      qd_r[0]   <= turn_nxt[TURN_W-1:TURN_W-2];
    end
  end

  // translation magnitudes, held until the squared scale is ready
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        tmag_r[1][j] <= tsum_r[j][TW-1] ? TW'(-tsum_r[j]) : TW'(tsum_r[j]);
        tneg_r[1][j] <= tsum_r[j][TW-1];
      end
    end
    for (int k = 2; k <= S2_ST; k++) begin
      if (en[k]) begin
        tmag_r[k] <= tmag_r[k-1];
        tneg_r[k] <= tneg_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- squared scale
  ptm_mul #(.AW(DW), .BW(DW), .DW(DW)) u_mul_s2 (
    .clk   (clk),
    .en    (en[S2_ST:1]),
    .a_mag (sc_mag_r),
    .b_mag (sc_mag_r),
    .neg   (1'b0),
    .res_r (s2_res)
  );

  // ---------------------------------------------------------------- translation
  for (genvar j = 0; j < 3; j++) begin : g_move
    ptm_mul #(.AW(DW-1), .BW(TW), .DW(DW)) u_mul_move (
      .clk   (clk),
      .en    (en[MV_ST:S2_ST+1]),
      .a_mag (s2_res[DW-2:0]),
      .b_mag (tmag_r[S2_ST][j]),
      .neg   (tneg_r[S2_ST][j]),
      .res_r (mv_res[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en[S2_ST+1]) s2_r[S2_ST+1] <= s2_res;
    for (int k = S2_ST + 2; k <= ST_OUT; k++) begin
      if (en[k]) s2_r[k] <= s2_r[k-1];
    end
    if (en[MV_ST+1]) mv_r[MV_ST+1] <= mv_res;
    for (int k = MV_ST + 2; k <= ST_OUT; k++) begin
      if (en[k]) mv_r[k] <= mv_r[k-1];
    end
  end

  // ---------------------------------------------------------------- CORDIC
  for (genvar i = 0; i < ITERS; i++) begin : g_cordic
    ptm_pkg::cordic_t dx_nxt, dy_nxt, at_nxt;

    assign dx_nxt = cy_r[i] >>> i;
    assign dy_nxt = cx_r[i] >>> i;
    assign at_nxt = ptm_pkg::cordic_t'(ptm_pkg::ATAN_TURNS[i]);

    // rotate toward zero residual angle; zero counts as positive
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (!cz_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] - dx_nxt;
          cy_r[i+1] <= cy_r[i] + dy_nxt;
          cz_r[i+1] <= cz_r[i] - at_nxt;
        end else begin
          cx_r[i+1] <= cx_r[i] + dx_nxt;
          cy_r[i+1] <= cy_r[i] - dy_nxt;
          cz_r[i+1] <= cz_r[i] + at_nxt;
        end
        qd_r[i+1] <= qd_r[i];
      end
    end
  end

  // ---------------------------------------------------------------- quadrant map
  // sin and cos leave here as magnitude and sign for the multipliers
  always_comb begin
    cr_nxt  = ptm_pkg::cordic_to_q16(cx_r[ITERS]);
    sr_nxt  = ptm_pkg::cordic_to_q16(cy_r[ITERS]);
    crm_nxt = ptm_pkg::trig_mag(cr_nxt);
    srm_nxt = ptm_pkg::trig_mag(sr_nxt);
    case (qd_r[ITERS])
      ptm_pkg::QUAD_0: begin
        c_mag_nxt = crm_nxt;  c_neg_nxt = cr_nxt[ptm_pkg::TRIG_W-1];
        s_mag_nxt = srm_nxt;  s_neg_nxt = sr_nxt[ptm_pkg::TRIG_W-1];
      end
      ptm_pkg::QUAD_1: begin
        c_mag_nxt = srm_nxt;  c_neg_nxt = !sr_nxt[ptm_pkg::TRIG_W-1];
        s_mag_nxt = crm_nxt;  s_neg_nxt = cr_nxt[ptm_pkg::TRIG_W-1];
      end
      ptm_pkg::QUAD_2: begin
        c_mag_nxt = crm_nxt;  c_neg_nxt = !cr_nxt[ptm_pkg::TRIG_W-1];
        s_mag_nxt = srm_nxt;  s_neg_nxt = !sr_nxt[ptm_pkg::TRIG_W-1];
      end
      default: begin
        c_mag_nxt = srm_nxt;  c_neg_nxt = sr_nxt[ptm_pkg::TRIG_W-1];
        s_mag_nxt = crm_nxt;  s_neg_nxt = !cr_nxt[ptm_pkg::TRIG_W-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_MAP]) begin
      c_mag_r <= c_mag_nxt;
      c_neg_r <= c_neg_nxt;
      s_mag_r <= s_mag_nxt;
      s_neg_r <= s_neg_nxt;
    end
  end

  // ---------------------------------------------------------------- rotation terms
  ptm_mul #(.AW(DW-1), .BW(ptm_pkg::TRIG_MAG_W), .DW(DW)) u_mul_cos (
    .clk   (clk),
    .en    (en[ST_OUT:ST_PP]),
    .a_mag (s2_r[ST_MAP][DW-2:0]),
    .b_mag (c_mag_r),
    .neg   (c_neg_r),
    .res_r (cos_res)
  );

  ptm_mul #(.AW(DW-1), .BW(ptm_pkg::TRIG_MAG_W), .DW(DW)) u_mul_sin (
    .clk   (clk),
    .en    (en[ST_OUT:ST_PP]),
    .a_mag (s2_r[ST_MAP][DW-2:0]),
    .b_mag (s_mag_r),
    .neg   (s_neg_r),
    .res_r (sin_res)
  );

  // ---------------------------------------------------------------- output
  assign out_beat.valid       = v_r[ST_OUT];
  assign out_beat.rot_cos_a   = cos_res;
  assign out_beat.rot_neg_sin = -sin_res;
  assign out_beat.rot_sin     = sin_res;
  assign out_beat.rot_cos_b   = cos_res;
  assign out_beat.depth_scale = s2_r[ST_OUT];
  assign out_beat.move_x      = mv_r[ST_OUT][0];
  assign out_beat.move_y      = mv_r[ST_OUT][1];
  assign out_beat.move_z      = mv_r[ST_OUT][2];

endmodule

FILE: rtl/core/ptm_check.sv
module ptm_check #(
  parameter int DW = 32
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] rot_cos_a,
  input logic signed [DW-1:0] rot_neg_sin,
  input logic signed [DW-1:0] rot_sin,
  input logic signed [DW-1:0] rot_cos_b,
  input logic signed [DW-1:0] depth_scale
);

  logic [7:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count beats taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rot_sin) && $stable(depth_scale))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result with no beat pending");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 8'd0 |-> in_ready)
    else $error("empty block refuses input");

  a_matrix_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rot_neg_sin == -rot_sin && rot_cos_a == rot_cos_b && !depth_scale[DW-1])
    else $error("matrix entries inconsistent");

endmodule

bind particle_transform_matrix ptm_check #(.DW(DATA_WIDTH)) u_ptm_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_beat.valid),
  .in_ready    (in_beat.ready),
  .out_valid   (out_beat.valid),
  .out_ready   (out_beat.ready),
  .rot_cos_a   (out_beat.rot_cos_a),
  .rot_neg_sin (out_beat.rot_neg_sin),
  .rot_sin     (out_beat.rot_sin),
  .rot_cos_b   (out_beat.rot_cos_b),
  .depth_scale (out_beat.depth_scale)
);
